// ===== rtl/core/fccw_pkg.sv =====
// Shared types and constants for the FAT12 cluster chain walker.
// No dependencies; imported by the top level and its checker.
`default_nettype none

package fccw_pkg;

  typedef logic [1:0] opcode_t;
  localparam opcode_t OP_WRITE = 2'd0;
  localparam opcode_t OP_START = 2'd1;
  localparam opcode_t OP_NEXT  = 2'd2;

  typedef logic [2:0] reg_index_t;
  localparam reg_index_t REG_RESERVED_SECTORS    = 3'd0;
  localparam reg_index_t REG_FAT_COPIES          = 3'd1;
  localparam reg_index_t REG_SECTORS_PER_FAT     = 3'd2;
  localparam reg_index_t REG_ROOT_ENTRIES        = 3'd3;
  localparam reg_index_t REG_SECTOR_SIZE_LOG2    = 3'd4;
  localparam reg_index_t REG_CLUSTER_SIZE        = 3'd5;

  localparam int CFG_DATA_W = 16;

  localparam logic [15:0] RESET_RESERVED_SECTORS    = 16'd1;
  localparam logic [2:0]  RESET_FAT_COPIES          = 3'd2;
  localparam logic [7:0]  RESET_SECTORS_PER_FAT     = 8'd9;
  localparam logic [15:0] RESET_ROOT_ENTRIES        = 16'd224;
  localparam logic [3:0]  RESET_SECTOR_SIZE_LOG2    = 4'd9;
  localparam logic [7:0]  RESET_CLUSTER_SIZE        = 8'd1;

  localparam logic [11:0] END_MARK = 12'hFF8;
  localparam logic [31:0] FIRST_DATA_CLUSTER = 32'd2;

  typedef enum logic {
    ST_IDLE,
    ST_READ
  } state_t;

endpackage

`default_nettype wire

// ===== rtl/core/fccw_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`default_nettype none

module fccw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/fat12_cluster_chain_walker.sv =====
// FAT12 cluster chain walker: FAT byte store in two banked RAMs, chain control.
// Depends on fccw_pkg and fccw_ram.
//
//   channel  direction  handshake              payload
//   cfg      in         cfg_write              cfg_index, cfg_data
//   in       in         in_valid / in_ready    opcode, fat_address, fat_byte, start_cluster
//   out      out        out_valid / out_ready  cluster, sector, fat_entry, last, status
//
// Write and start beats complete on acceptance. A next beat is accepted in ST_IDLE,
// which issues both FAT byte reads (even and odd bank, one port each) and the cluster
// offset multiply; ST_READ then unpacks the entry and adds the data start. A stalled
// output holds the block in its read state.
// Reset clears control state and loads register defaults; the FAT store is not
// cleared and holds whatever it held until written.
`default_nettype none

module fat12_cluster_chain_walker
  import fccw_pkg::*;
#(
  parameter int FAT_BYTES = 8192
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_write,
  input  wire logic [2:0]       cfg_index,
  input  wire logic [15:0]      cfg_data,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [1:0]       opcode,
  input  wire logic [12:0]      fat_address,
  input  wire logic [7:0]       fat_byte,
  input  wire logic [11:0]      start_cluster,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic      [11:0]      cluster,
  output logic      [31:0]      sector,
  output logic      [11:0]      fat_entry,
  output logic                  last,
  output logic                  status
);

  localparam int BANK_DEPTH = FAT_BYTES / 2;
  localparam int BW = $clog2(BANK_DEPTH);
  localparam logic [13:0] STORE_LIMIT = 14'(FAT_BYTES);

  // configuration
  logic [15:0] reserved_sectors;
  logic [2:0]  fat_copies;
  logic [7:0]  sectors_per_fat;
  logic [15:0] root_entries;
  logic [3:0]  sector_size_log2;
  logic [7:0]  cluster_size;
  logic [31:0] data_start;

  always_ff @(posedge clk) begin
    if (rst) begin
      reserved_sectors    <= RESET_RESERVED_SECTORS;
      fat_copies          <= RESET_FAT_COPIES;
      sectors_per_fat     <= RESET_SECTORS_PER_FAT;
      root_entries        <= RESET_ROOT_ENTRIES;
      sector_size_log2    <= RESET_SECTOR_SIZE_LOG2;
      cluster_size        <= RESET_CLUSTER_SIZE;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_RESERVED_SECTORS:    reserved_sectors    <= cfg_data;
        REG_FAT_COPIES:          fat_copies          <= cfg_data[2:0];
        REG_SECTORS_PER_FAT:     sectors_per_fat     <= cfg_data[7:0];
        REG_ROOT_ENTRIES:        root_entries        <= cfg_data;
        REG_SECTOR_SIZE_LOG2:    sector_size_log2    <= cfg_data[3:0];
        REG_CLUSTER_SIZE:        cluster_size        <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // data start, refreshed every cycle from the registers
  logic [21:0] root_bytes_round;
  logic [21:0] root_sectors;
  logic [10:0] fat_area;
  logic [31:0] data_start_next;

  always_comb begin
    root_bytes_round = {1'b0, root_entries, 5'b0} + (22'd1 << sector_size_log2) - 22'd1;
    root_sectors     = root_bytes_round >> sector_size_log2;
    fat_area         = 11'(fat_copies) * 11'(sectors_per_fat);
    data_start_next  = 32'(reserved_sectors) + 32'(fat_area) + 32'(root_sectors);
  end

  always_ff @(posedge clk) begin
    data_start <= data_start_next;
  end

  // chain state
  logic [11:0] chain_cluster;
  logic        chain_active;
  state_t      state;
  state_t      state_next;

  logic in_beat;
  logic out_free;
  logic issue_next;
  logic finish;

  assign in_beat  = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    issue_next = 1'b0;
    finish     = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid && opcode == OP_NEXT) begin
          issue_next = 1'b1;
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        // hold until the output register can take the result
        if (out_free) begin
          finish     = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // FAT store: even bank holds even byte addresses, odd bank the odd ones
  logic [12:0]    off;
  logic [12:0]    off1;
  logic           wr_ok;
  logic           we_even;
  logic           we_odd;
  logic [BW-1:0]  waddr;
  logic [BW-1:0]  raddr_even;
  logic [BW-1:0]  raddr_odd;
  logic [7:0]     rdata_even;
  logic [7:0]     rdata_odd;

  always_comb begin
    off        = 13'((14'(chain_cluster) * 14'd3) >> 1);
    off1       = off + 13'd1;
    raddr_even = off1[BW:1];
    raddr_odd  = off[BW:1];
    wr_ok      = in_beat && opcode == OP_WRITE && {1'b0, fat_address} < STORE_LIMIT;
    we_even    = wr_ok && !fat_address[0];
    we_odd     = wr_ok && fat_address[0];
    waddr      = fat_address[BW:1];
  end

  fccw_ram #(
    .WIDTH(8),
    .DEPTH(BANK_DEPTH)
  ) u_even_bank (
    .clk  (clk),
    .we   (we_even),
    .waddr(waddr),
    .wdata(fat_byte),
    .re   (issue_next),
    .raddr(raddr_even),
    .rdata(rdata_even)
  );

  fccw_ram #(
    .WIDTH(8),
    .DEPTH(BANK_DEPTH)
  ) u_odd_bank (
    .clk  (clk),
    .we   (we_odd),
    .waddr(waddr),
    .wdata(fat_byte),
    .re   (issue_next),
    .raddr(raddr_odd),
    .rdata(rdata_odd)
  );

  // per-item registers captured at issue
  logic [11:0] rd_cluster;
  logic        rd_error;
  logic        rd_off_odd;
  logic        rd_lo_ok;
  logic        rd_hi_ok;
  logic [31:0] rd_offset;

  always_ff @(posedge clk) begin
    if (issue_next) begin
      rd_cluster <= chain_cluster;
      rd_error   <= !chain_active;
      rd_off_odd <= off[0];
      rd_lo_ok   <= {1'b0, off} < STORE_LIMIT;
      rd_hi_ok   <= {1'b0, off1} < STORE_LIMIT;
      rd_offset  <= ({20'b0, chain_cluster} - FIRST_DATA_CLUSTER) * 32'(cluster_size);
    end
  end

  // unpack the entry
  logic [7:0]  lo_byte;
  logic [7:0]  hi_byte;
  logic [11:0] entry;
  logic        entry_last;

  always_comb begin
    lo_byte = rd_off_odd ? rdata_odd : rdata_even;
    hi_byte = rd_off_odd ? rdata_even : rdata_odd;
    if (!rd_lo_ok) lo_byte = 8'd0;
    if (!rd_hi_ok) hi_byte = 8'd0;
    entry = rd_cluster[0] ? {hi_byte, lo_byte[7:4]} : {hi_byte[3:0], lo_byte};
    entry_last = entry >= END_MARK;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chain_cluster <= 12'd0;
      chain_active  <= 1'b0;
    end else if (in_beat && opcode == OP_START) begin
      chain_cluster <= start_cluster;
      chain_active  <= 1'b1;
    end else if (finish && !rd_error) begin
      chain_cluster <= entry;
      if (entry_last) chain_active <= 1'b0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      if (rd_error) begin
        cluster      <= 12'd0;
        sector       <= 32'd0;
        fat_entry    <= 12'd0;
        last         <= 1'b0;
        status       <= 1'b1;
      end else begin
        cluster      <= rd_cluster;
        sector       <= data_start + rd_offset;
        fat_entry    <= entry;
        last         <= entry_last;
        status       <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/fccw_checker.sv =====
// Port-level checks for the FAT12 cluster chain walker, bound to the top level.
// Depends on fccw_pkg.
`default_nettype none

module fccw_checker
  import fccw_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic [1:0]  opcode,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [11:0] cluster,
  input wire logic [31:0] sector,
  input wire logic [11:0] fat_entry,
  input wire logic        last,
  input wire logic        status
);

  // a stalled result beat holds its sector, fat entry and status
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(sector) && $stable(fat_entry)
                                && $stable(status))
    else $error("stalled result beat changed");

  // an error beat carries all-zero result fields
  assert property (@(posedge clk) disable iff (rst)
    out_valid && status |-> cluster == 12'd0 && sector == 32'd0
                            && fat_entry == 12'd0 && !last)
    else $error("error beat with nonzero fields");

  // last flags exactly the end marks
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !status |-> last == (fat_entry >= END_MARK))
    else $error("last does not match end mark");

  // a next beat occupies the input during its FAT read
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && opcode == OP_NEXT |=> !in_ready)
    else $error("input taken during FAT read");

  assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result beat right after reset");

endmodule

bind fat12_cluster_chain_walker fccw_checker u_checker (.*);

`default_nettype wire
